// ----- design/npos_pkg.sv -----
// Shared types and constants for the nth pattern occurrence search block.
package npos_pkg;

    localparam int DATA_W      = 8;
    localparam int IDX_W       = 4;
    localparam int LEN_W       = 5;
    localparam int SKIP_W      = 16;
    localparam int OFF_W       = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [OFF_W-1:0]  POS_SAT    = 16'hFFFF;
    localparam logic [QCNT_W-1:0] QCNT_FULL  = 3'd4;

    // Register index, taken from paddr[2]
    localparam logic REG_LEN  = 1'b0;
    localparam logic REG_SKIP = 1'b1;

    typedef enum logic [0:0] {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              wr_en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [SKIP_W-1:0] skip;
    } t_cfg;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] offset;
    } t_res;

endpackage

// ----- design/npos_front.sv -----
// Input side: takes transfers, classifies them and queues them for the search core.
module npos_front #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic [npos_pkg::DATA_W-1:0] i_data,
    input  logic [npos_pkg::IDX_W-1:0]  i_idx,
    input  logic                      i_last,
    output npos_pkg::t_cmd            o_cmd,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_pop
);
    import npos_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              r_run;
    logic              push;
    t_cmd              cmd_in;

    assign o_ready     = r_run && (r_cnt != QCNT_FULL);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Tag the item and check the pattern index against the store depth
    always_comb begin
        cmd_in.kind  = t_kind'(i_op);
        cmd_in.wr_en = (t_kind'(i_op) == KIND_PATTERN) && (int'(i_idx) < PATTERN_MAX);
        cmd_in.idx   = i_idx;
        cmd_in.data  = i_data;
        cmd_in.last  = i_last;
    end

    always_comb begin
        n_wp  = push ? r_wp + QPTR_W'(1) : r_wp;
        n_rp  = i_cmd_pop ? r_rp + QPTR_W'(1) : r_rp;
        n_cnt = r_cnt + QCNT_W'(push) - QCNT_W'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_run <= 1'b0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
            r_run <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ----- design/npos_back.sv -----
// Search core: pattern store, text window, match check and result register.
module npos_back #(
    parameter int PATTERN_MAX = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  npos_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  npos_pkg::t_cfg i_cfg,
    output logic           o_res_valid,
    output npos_pkg::t_res o_res,
    input  logic           i_res_ready
);
    import npos_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic [DATA_W-1:0]                   r_pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0][DATA_W-1:0]  r_win, n_win, win_sh;
    logic [PATTERN_MAX*DATA_W-1:0]       rv_flat, al_flat;
    logic [OFF_W-1:0]                    r_pos, n_pos, off;
    logic [SKIP_W-1:0]                   r_seen, n_seen;
    logic [LW-1:0]                       r_guard, n_guard, g_inc, len, sh;
    logic                                r_done, n_done;
    logic                                r_out_valid, n_out_valid;
    t_res                                r_res, n_res;
    logic [PATTERN_MAX-1:0]              eq;
    logic                                hit, text_go, pat_go;

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_res_ready);
    assign text_go     = o_cmd_pop && (i_cmd.kind == KIND_TEXT);
    assign pat_go      = o_cmd_pop && (i_cmd.kind == KIND_PATTERN) && i_cmd.wr_en;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    // Clamp the configured length to the store depth
    always_comb begin
        if (int'(i_cfg.len) > PATTERN_MAX) begin
            len = LW'(PATTERN_MAX);
        end else begin
            len = LW'(i_cfg.len);
        end
    end

    // Window after shifting in the new byte; entry 0 is the newest
    always_comb begin
        win_sh[0] = i_cmd.data;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            win_sh[k] = r_win[k-1];
        end
    end

    // Reverse the window and shift it down so that text byte j lines up with
    // pattern byte j of the active length
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            rv_flat[j*DATA_W +: DATA_W] = win_sh[PATTERN_MAX-1-j];
        end
        sh      = LW'(PATTERN_MAX) - len;
        al_flat = rv_flat >> {sh, 3'b000};
        for (int j = 0; j < PATTERN_MAX; j++) begin
            eq[j] = (j >= int'(len)) || (al_flat[j*DATA_W +: DATA_W] == r_pat[j]);
        end
        hit = &eq;
    end

    assign g_inc = (r_guard < LW'(PATTERN_MAX)) ? r_guard + LW'(1) : r_guard;
    assign off   = (r_pos == POS_SAT) ? POS_SAT : r_pos - (OFF_W'(len) - OFF_W'(1));

    always_comb begin
        n_win       = r_win;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_guard     = r_guard;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_res_ready;
        n_res       = r_res;
        if (text_go) begin
            if (!r_done) begin
                n_win   = win_sh;
                n_pos   = (r_pos == POS_SAT) ? r_pos : r_pos + OFF_W'(1);
                n_guard = g_inc;
                if (len == '0) begin
                    n_out_valid  = 1'b1;
                    n_res.found  = 1'b1;
                    n_res.offset = '0;
                    n_done       = 1'b1;
                end else if ((g_inc >= len) && hit) begin
                    if (r_seen >= i_cfg.skip) begin
                        n_out_valid  = 1'b1;
                        n_res.found  = 1'b1;
                        n_res.offset = off;
                        n_done       = 1'b1;
                    end else begin
                        // Passed-over match: resume just past its end
                        n_seen  = r_seen + SKIP_W'(1);
                        n_guard = '0;
                    end
                end
            end
            if (i_cmd.last) begin
                if (!n_done) begin
                    n_out_valid  = 1'b1;
                    n_res.found  = 1'b0;
                    n_res.offset = '0;
                end
                n_win   = '0;
                n_pos   = '0;
                n_seen  = '0;
                n_guard = '0;
                n_done  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_pos       <= '0;
            r_seen      <= '0;
            r_guard     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_guard     <= n_guard;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (pat_go && (int'(i_cmd.idx) == j)) begin
                r_pat[j] <= i_cmd.data;
            end
        end
    end

endmodule

// ----- design/nth_pattern_occurrence_search.sv -----
// Top level of the nth pattern occurrence search: stream ports, register port, front and core.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata {pattern_index, data_byte}, tuser op,
//                                              tlast last_text
//  m_axis    out        tvalid/tready          tdata match_offset, tuser found
//  apb       in/out     psel/penable/pready    pattern_length @0x0, occurrences_to_skip @0x4
//
// Throughput is one transfer per cycle on s_axis, pattern loads and text bytes alike, while the
// queue has room; the core retires one queued item per cycle while m_axis is not stalled,
// bounded by its single window compare. After the input transfer that causes it, a result
// passes through the queue entry, then the core result register; queued items ahead delay it.
// Reset is synchronous and active low; s_axis_tready stays low until the cycle after it.
// A stalled m_axis holds the result; the 4-entry queue keeps taking input until full.
module nth_pattern_occurrence_search #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [7:0] data_byte, [11:8] pattern_index
    input  logic [0:0]                    s_axis_tuser,   // [0] op
    input  logic                          s_axis_tlast,
    // stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [15:0] match_offset
    output logic [0:0]                    m_axis_tuser,   // [0] found
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [npos_pkg::PADDR_W-1:0]  paddr,
    input  logic [npos_pkg::PDATA_W-1:0]  pwdata,
    output logic [npos_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import npos_pkg::*;

    logic [LEN_W-1:0]  r_len;
    logic [SKIP_W-1:0] r_skip;
    t_cfg              cfg;
    t_cmd              cmd;
    logic              cmd_valid, cmd_pop;
    t_res              res;
    logic              wr_go;

    // Register writes complete in the access cycle; the block never waits
    assign pready = 1'b1;
    assign wr_go  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_skip <= '0;
        end else if (wr_go) begin
            case (paddr[2])
                REG_LEN:  r_len  <= pwdata[LEN_W-1:0];
                REG_SKIP: r_skip <= pwdata[SKIP_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LEN:  prdata = PDATA_W'(r_len);
            REG_SKIP: prdata = PDATA_W'(r_skip);
            default:  prdata = '0;
        endcase
    end

    assign cfg.len  = r_len;
    assign cfg.skip = r_skip;

    // Front: accept and queue
    npos_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser[0]),
        .i_data      (s_axis_tdata[7:0]),
        .i_idx       (s_axis_tdata[11:8]),
        .i_last      (s_axis_tlast),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: window compare, counting and result
    npos_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (cfg),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata    = res.offset;
    assign m_axis_tuser[0] = res.found;

endmodule

// ----- design/npos_checker.sv -----
// Port-level checks for the nth pattern occurrence search, bound to the top level.
module npos_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A miss always carries offset zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("miss with nonzero offset");

    // Nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("handshake active after reset");

    // A length write reads back on the next cycle
    a_len_readback: assert property (@(posedge i_clk)
        i_rst_n && psel && penable && pwrite && pready && paddr[2] == 1'b0 |=>
            !i_rst_n || !(psel && !pwrite && paddr[2] == 1'b0) ||
            prdata[4:0] == $past(pwdata[4:0]))
        else $error("length register readback mismatch");

endmodule

bind nth_pattern_occurrence_search npos_checker u_npos_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the nth pattern occurrence search block.
module tb_top;
    import npos_pkg::*;

    // Clock and run control
    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1850;   // random stream items; the last phase runs over
    localparam int PHASE_ITEMS   = 150;    // items per register setting
    localparam int STALL_PHASE   = 7;      // setting during which the sink holds off
    localparam int LONG_HOLD     = 300;    // sink hold-off, in cycles
    localparam int SETTLE_CYCLES = 10;     // drain of loads that give no report
    localparam int WATCHDOG_MAX  = 2000;   // cycles with no transfer before giving up
    localparam int PAT_DEPTH     = 16;

    localparam logic [PADDR_W-1:0] ADDR_LEN  = {REG_LEN, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SKIP = {REG_SKIP, 2'b00};

    // One stream item as queued for the driver
    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_item;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;    // [7:0] data_byte, [11:8] pattern_index
    logic [0:0]         s_axis_tuser  = '0;    // [0] op
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;          // [15:0] match_offset
    logic [0:0]         m_axis_tuser;          // [0] found
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    nth_pattern_occurrence_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow search: its own copy of the pattern, the text history, the
    // counters and the two registers. Advanced once per accepted transfer.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] pat_shadow [PAT_DEPTH] = '{default: '0};
    logic [DATA_W-1:0] text_hist  [PAT_DEPTH] = '{default: '0};  // [0] is the newest byte
    logic [OFF_W-1:0]  bytes_seen   = '0;
    logic [SKIP_W-1:0] hits_passed  = '0;
    logic [LEN_W-1:0]  since_resume = '0;
    logic              reported     = 1'b0;
    logic [LEN_W-1:0]  cfg_len      = '0;
    logic [SKIP_W-1:0] cfg_skip     = '0;

    t_res  expected_reports [$];   // reports the block still owes, oldest first
    t_item stream_items     [$];   // items waiting for the driver, head is on the bus

    int unsigned fail_count = 0;
    int unsigned n_text = 0, n_loads = 0, n_found = 0, n_missed = 0, n_settings = 0;

    // Compare the newest n text bytes against the first n pattern bytes
    function automatic logic window_hit(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            if (text_hist[k] != pat_shadow[n - 1 - k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_search();
        text_hist    = '{default: '0};
        bytes_seen   = '0;
        hits_passed  = '0;
        since_resume = '0;
        reported     = 1'b0;
    endtask

    task automatic advance_search(input t_item it);
        int unsigned      eff_len;
        logic [OFF_W-1:0] start_pos;
        t_res             rep;
        if (it.kind == KIND_PATTERN) begin
            pat_shadow[it.idx] = it.data;
            return;
        end
        // lengths above the store depth act as the full depth
        eff_len = (cfg_len > PAT_DEPTH) ? PAT_DEPTH : cfg_len;
        if (!reported) begin
            start_pos = bytes_seen;
            for (int k = PAT_DEPTH - 1; k > 0; k--)
                text_hist[k] = text_hist[k - 1];
            text_hist[0] = it.data;
            if (bytes_seen != POS_SAT)
                bytes_seen++;
            if (since_resume < PAT_DEPTH)
                since_resume++;
            if (eff_len == 0) begin
                // empty pattern matches at the start, skip count or not
                rep.found  = 1'b1;
                rep.offset = '0;
                expected_reports.push_back(rep);
                reported = 1'b1;
            end else if (since_resume >= eff_len && window_hit(eff_len)) begin
                if (hits_passed >= cfg_skip) begin
                    rep.found  = 1'b1;
                    rep.offset = (start_pos == POS_SAT) ? POS_SAT
                                                        : start_pos - OFF_W'(eff_len - 1);
                    expected_reports.push_back(rep);
                    reported = 1'b1;
                end else begin
                    // pass this hit over and restart just past it
                    hits_passed++;
                    since_resume = '0;
                end
            end
        end
        if (it.last) begin
            if (!reported) begin
                rep.found  = 1'b0;
                rep.offset = '0;
                expected_reports.push_back(rep);
            end
            clear_search();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the head of stream_items at the falling edge, in
    // bursts of random length separated by random gaps. The head is popped
    // by the monitor when the transfer completes.
    // ------------------------------------------------------------------
    logic        in_taken   = 1'b0;   // input transfer seen at the last rising edge
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (s_axis_tvalid && !in_taken) begin
            // hold the offered item until the block takes it
        end else if (gap_left != 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left = gap_left - 1;
        end else if (stream_items.size() != 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {4'b0000, stream_items[0].idx, stream_items[0].data};
            s_axis_tuser  <= stream_items[0].kind;
            s_axis_tlast  <= stream_items[0].last;
            if (burst_left <= 1) begin
                // new burst; half of the bursts follow on with no gap at all
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left = burst_left - 1;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sink: ready follows a duty cycle that changes at random intervals.
    // Once asked, it holds ready low until hold_cnt reaches LONG_HOLD, so the block backs up.
    // ------------------------------------------------------------------
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_cnt  = 0;
    int unsigned ready_pct = 100;
    int unsigned mode_left = 0;

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cnt = hold_cnt + 1;
            if (hold_cnt == LONG_HOLD)
                hold_done = 1'b1;
        end else begin
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                mode_left = $urandom_range(8, 80);
            end else begin
                mode_left = mode_left - 1;
            end
            m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check reports first, then advance the shadow search with any
    // input transfer of the same edge. The watchdog lives here too.
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin : monitor
        t_res  got;
        t_res  want;
        t_item it;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found  = m_axis_tuser[0];
                got.offset = m_axis_tdata;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, got found=%0d offset=%0d",
                             $time, got.found, got.offset);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch, expected %0d, got %0d",
                                 $time, want.found, got.found);
                        fail_count++;
                    end
                    if (got.offset !== want.offset) begin
                        $display("%0t: match_offset mismatch, expected %0d, got %0d",
                                 $time, want.offset, got.offset);
                        fail_count++;
                    end
                    if (want.found)
                        n_found++;
                    else
                        n_missed++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it.kind = t_kind'(s_axis_tuser[0]);
                it.data = s_axis_tdata[7:0];
                it.idx  = s_axis_tdata[11:8];
                it.last = s_axis_tlast;
                advance_search(it);
                void'(stream_items.pop_front());
                if (it.kind == KIND_TEXT)
                    n_text++;
                else
                    n_loads++;
            end
        end
        // count cycles with no progress on any port
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_MAX) begin
            $display("%0t: no transfer for %0d cycles, %0d items and %0d reports outstanding",
                     $time, WATCHDOG_MAX, stream_items.size(), expected_reports.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] gen_pat  [PAT_DEPTH];  // pattern as the generator last wrote it
    logic [DATA_W-1:0] alphabet [3];          // small byte set so hits are frequent
    int unsigned       alpha_n      = 2;
    int unsigned       items_queued = 0;

    task automatic queue_item(input t_kind kind, input logic [DATA_W-1:0] data,
                              input logic [IDX_W-1:0] idx, input logic last);
        t_item it;
        it.kind = kind;
        it.data = data;
        it.idx  = idx;
        it.last = last;
        stream_items.push_back(it);
        items_queued++;
        if (kind == KIND_PATTERN)
            gen_pat[idx] = data;
    endtask

    // Text bytes carry a random index field; the block must ignore it
    task automatic queue_text(input logic [DATA_W-1:0] data, input logic last);
        queue_item(KIND_TEXT, data, IDX_W'($urandom_range(0, PAT_DEPTH - 1)), last);
    endtask

    function automatic logic [DATA_W-1:0] text_byte();
        if ($urandom_range(0, 99) < 8)
            return DATA_W'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alpha_n - 1)];
    endfunction

    // One search: pattern copies, broken prefixes, loose bytes and the odd
    // pattern load, closed by a byte with last set
    task automatic queue_search(input int unsigned eff_len, input int unsigned max_len);
        int unsigned n;
        int unsigned j;
        int unsigned cut;
        int unsigned r;
        n = $urandom_range(1, max_len);
        j = 0;
        while (j < n) begin
            r = $urandom_range(0, 19);
            if (r < 6 && eff_len != 0) begin
                for (int unsigned k = 0; k < eff_len; k++)
                    queue_text(gen_pat[k], 1'b0);
                j += eff_len;
            end else if (r < 9 && eff_len > 1) begin
                cut = $urandom_range(1, eff_len - 1);
                for (int unsigned k = 0; k < cut; k++)
                    queue_text(gen_pat[k], 1'b0);
                j += cut;
            end else if (r == 9) begin
                queue_item(KIND_PATTERN, alphabet[$urandom_range(0, alpha_n - 1)],
                           IDX_W'($urandom_range(0, PAT_DEPTH - 1)),
                           1'($urandom_range(0, 1)));
            end else begin
                queue_text(text_byte(), 1'b0);
                j++;
            end
        end
        queue_text(text_byte(), 1'b1);
    endtask

    // Idle point: every item taken, every report in, pattern loads drained
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (stream_items.size() != 0 || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write a register, then read it back
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input int unsigned value);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        if (addr == ADDR_LEN) begin
            cfg_len = LEN_W'(value);
            want    = PDATA_W'(cfg_len);
        end else begin
            cfg_skip = SKIP_W'(value);
            want     = PDATA_W'(cfg_skip);
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== want) begin
            $display("%0t: register 0x%0h readback mismatch, expected %0d, got %0d",
                     $time, addr, want, readback);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        int unsigned first_random;
        int unsigned phase_start;
        int unsigned len_set;
        int unsigned skip_set;
        int unsigned eff_len;
        int unsigned max_len;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pattern first, with every pattern entry loaded
        // (extreme bytes at the low entries, last toggling on loads)
        write_reg(ADDR_LEN, 0);
        write_reg(ADDR_SKIP, 0);
        n_settings++;
        for (int unsigned k = 0; k < PAT_DEPTH; k++)
            queue_item(KIND_PATTERN, (k == 0) ? 8'hFF : (k == 1) ? 8'h00
                                                : DATA_W'($urandom_range(0, 255)),
                       IDX_W'(k), k[0]);
        queue_text(8'h7E, 1'b0);   // reports at offset 0 right away
        queue_text(8'h00, 1'b1);   // ignored, closes the search

        // Directed: pass one hit over, load an unused entry mid-search, report
        // the next hit, then bytes that must be ignored until last
        wait_idle();
        write_reg(ADDR_LEN, 2);
        write_reg(ADDR_SKIP, 1);
        n_settings++;
        queue_text(8'hFF, 1'b0);
        queue_text(8'h00, 1'b0);
        queue_item(KIND_PATTERN, 8'h5A, IDX_W'(PAT_DEPTH - 1), 1'b1);
        queue_text(8'hFF, 1'b0);
        queue_text(8'h00, 1'b0);
        queue_text(8'hFF, 1'b0);
        queue_text(8'h00, 1'b1);

        // Random part: a fixed list of settings with the extremes, then
        // random settings. Every setting change waits for the block to go
        // idle, so the sender also pauses until all reports are in.
        phase        = 0;
        first_random = items_queued;
        while (items_queued - first_random < RANDOM_ITEMS) begin
            case (phase)
                0:  begin len_set = 1;  skip_set = 0;     end
                1:  begin len_set = 2;  skip_set = 1;     end
                2:  begin len_set = 3;  skip_set = 0;     end
                3:  begin len_set = 16; skip_set = 0;     end
                4:  begin len_set = 4;  skip_set = 65535; end
                5:  begin len_set = 20; skip_set = 2;     end
                6:  begin len_set = 0;  skip_set = 7;     end
                7:  begin len_set = 1;  skip_set = 0;     end
                8:  begin len_set = 5;  skip_set = 3;     end
                9:  begin len_set = 31; skip_set = 1;     end
                10: begin len_set = 8;  skip_set = 65535; end
                default: begin
                    len_set  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                           : $urandom_range(0, 16);
                    skip_set = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 4);
                end
            endcase
            wait_idle();
            write_reg(ADDR_LEN, len_set);
            write_reg(ADDR_SKIP, skip_set);
            n_settings++;
            eff_len = (len_set > PAT_DEPTH) ? PAT_DEPTH : len_set;

            // fresh alphabet; sometimes the two extreme bytes take its first two places
            alpha_n = $urandom_range(2, 3);
            for (int unsigned a = 0; a < 3; a++)
                alphabet[a] = DATA_W'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
                alphabet[0] = 8'h00;
                alphabet[1] = 8'hFF;
            end
            for (int unsigned k = 0; k < eff_len; k++)
                queue_item(KIND_PATTERN, alphabet[$urandom_range(0, alpha_n - 1)],
                           IDX_W'(k), 1'($urandom_range(0, 1)));

            // short searches give frequent reports, so the hold-off backs
            // the block up and stalls its input
            max_len = (phase == STALL_PHASE) ? 3 : (eff_len > 8) ? 64 : 40;
            if (phase == STALL_PHASE)
                hold_req = 1'b1;
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS)
                queue_search(eff_len, max_len);
            // leave a search open now and then, so the next register write
            // lands in the middle of it
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 5)) queue_text(text_byte(), 1'b0);
            phase++;
        end
        queue_text(8'h00, 1'b1);

        wait_idle();
        $display("Covered %0d text bytes and %0d pattern loads over %0d register settings,",
                 n_text, n_loads, n_settings);
        $display("with %0d reports of a hit and %0d of a text ending without one.",
                 n_found, n_missed);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/npos_pkg.sv
design/npos_front.sv
design/npos_back.sv
design/nth_pattern_occurrence_search.sv
design/npos_checker.sv
tb/tb_top.sv
